// ===== hdl/dqpb_pkg.sv =====
package dqpb_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int HDR_BYTES   = 12;
  localparam int TRL_BYTES   = 5;
  localparam int CNT_W       = 4;

  localparam logic [7:0] SEPARATOR = 8'h2E;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_QUERY_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OPCODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RECURSION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_QTYPE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_QCLASS    = 3'd4;

  typedef struct packed {
    logic [15:0] id_word;
    logic [3:0]  opcode;
    logic        rd_flag;
    logic [15:0] qtype;
    logic [15:0] qclass;
  } cfg_t;

endpackage

// ===== hdl/dns_query_packet_builder_core.sv =====
// dns query packet builder
// in_*  : one name character per transaction, in_tdata = name_char, in_tlast
//         on the final character of the name; '.' separates labels
// out_* : one packet byte per transaction in wire order, out_tlast on the
//         class low byte, out_tuser set there when a label was truncated
// cfg_* : register writes (query id, opcode, recursion bit, type, class),
//         to be issued only while no packet is in flight
// an ordinary character goes straight into the label ram unless the label
// is full. the first character of a packet adds 12 header bytes, a
// separator replays the label (length byte, then the ram is read one byte
// per cycle unless the output stalls, next address issued as each byte
// leaves), the final character adds the last label plus 5 trailer bytes.
// the first output byte passes the header state, then the output register.
// a stall on out_tready freezes the sequencer; the output register keeps
// its byte and input is refused until the sequencer is back to idle.
// reset clears the sequencer, the fill count and the packet flags and
// loads the register defaults; the label ram is not cleared.
module dns_query_packet_builder_core #(
  parameter int LABEL_MAX = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // name_char
  input  logic                           in_tlast,   // name_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // packet_byte
  output logic                           out_tlast,  // packet_last
  output logic                           out_tuser,  // label_overflow
  input  logic                           cfg_we,
  input  logic [dqpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dqpb_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int FW = $clog2(LABEL_MAX + 1);
  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int CW = dqpb_pkg::CNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_DAT  = 3'd3;
  localparam logic [2:0] ST_TRL  = 3'd4;

  dqpb_pkg::cfg_t cfg;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] k_r, k_nxt;
  logic          open_r, open_nxt;
  logic          ovf_r, ovf_nxt;
  logic          sep_r, sep_nxt;
  logic          last_r, last_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  logic          in_acc, out_free, emit;
  logic          in_sep;
  logic [FW-1:0] k_inc;
  logic [7:0]    hdr_byte, trl_byte;

  dqpb_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  dqpb_ram #(
    .WIDTH (8),
    .DEPTH (LABEL_MAX)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // where to go once a character has been stored and any header sent
  function automatic logic [2:0] route_char(input logic sep, input logic last,
                                            input logic have_label);
    logic [2:0] r;
    r = ST_IDLE;
    if (sep || last) begin
      if (have_label) begin
        r = ST_LEN;
      end else if (last) begin
        r = ST_TRL;
      end
    end
    return r;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_sep    = (in_tdata == dqpb_pkg::SEPARATOR);
  assign k_inc     = k_r + FW'(1);

  always_comb begin
    case (cnt_r)
      4'd0:    hdr_byte = cfg.id_word[15:8];
      4'd1:    hdr_byte = cfg.id_word[7:0];
      4'd2:    hdr_byte = {1'b0, cfg.opcode, 2'b00, cfg.rd_flag};
      4'd5:    hdr_byte = 8'd1;
      default: hdr_byte = 8'd0;
    endcase
    case (cnt_r)
      4'd1:    trl_byte = cfg.qtype[15:8];
      4'd2:    trl_byte = cfg.qtype[7:0];
      4'd3:    trl_byte = cfg.qclass[15:8];
      4'd4:    trl_byte = cfg.qclass[7:0];
      default: trl_byte = 8'd0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    k_nxt        = k_r;
    open_nxt     = open_r;
    ovf_nxt      = ovf_r;
    sep_nxt      = sep_r;
    last_nxt     = last_r;
    emit         = 1'b0;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    ram_we       = 1'b0;
    ram_waddr    = fill_r[AW-1:0];
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sep_nxt  = in_sep;
          last_nxt = in_tlast;
          open_nxt = 1'b1;
          if (!open_r) begin
            ovf_nxt = 1'b0;
          end
          // label ram is written only here, never while a label is replayed
          if (!in_sep) begin
            if (fill_r < FW'(LABEL_MAX)) begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + FW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (!open_r) begin
            state_nxt = ST_HDR;
            cnt_nxt   = '0;
          end else begin
            state_nxt = route_char(in_sep, in_tlast, fill_nxt != '0);
            cnt_nxt   = '0;
          end
        end
      end
      ST_HDR: begin
        if (out_free) begin
          emit         = 1'b1;
          out_data_nxt = hdr_byte;
          out_last_nxt = 1'b0;
          out_ovf_nxt  = 1'b0;
          cnt_nxt      = cnt_r + CW'(1);
          if (cnt_r == CW'(dqpb_pkg::HDR_BYTES - 1)) begin
            state_nxt = route_char(sep_r, last_r, fill_r != '0);
            cnt_nxt   = '0;
          end
        end
      end
      ST_LEN: begin
        if (out_free) begin
          emit         = 1'b1;
          out_data_nxt = 8'(fill_r);
          out_last_nxt = 1'b0;
          out_ovf_nxt  = 1'b0;
          ram_re       = 1'b1;
          ram_raddr    = '0;
          k_nxt        = '0;
          state_nxt    = ST_DAT;
        end
      end
      ST_DAT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_data_nxt = ram_rdata;
          out_last_nxt = 1'b0;
          out_ovf_nxt  = 1'b0;
          if (k_inc < fill_r) begin
            ram_re    = 1'b1;
            ram_raddr = k_inc[AW-1:0];
            k_nxt     = k_inc;
          end else begin
            fill_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = last_r ? ST_TRL : ST_IDLE;
          end
        end
      end
      ST_TRL: begin
        if (out_free) begin
          emit         = 1'b1;
          out_data_nxt = trl_byte;
          out_last_nxt = 1'b0;
          out_ovf_nxt  = 1'b0;
          cnt_nxt      = cnt_r + CW'(1);
          if (cnt_r == CW'(dqpb_pkg::TRL_BYTES - 1)) begin
            out_last_nxt = 1'b1;
            out_ovf_nxt  = ovf_r;
            open_nxt     = 1'b0;
            ovf_nxt      = 1'b0;
            fill_nxt     = '0;
            cnt_nxt      = '0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      open_r      <= 1'b0;
      ovf_r       <= 1'b0;
      sep_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      open_r      <= open_nxt;
      ovf_r       <= ovf_nxt;
      sep_r       <= sep_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(LABEL_MAX))
    else $error("label fill count beyond label size");

  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("overflow flag away from final byte");

  a_open_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !open_r |=> state_r == ST_HDR)
    else $error("new packet did not start with a header");

  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE && !ram_re)
    else $error("label ram written during replay");

  a_no_lost_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output byte dropped under stall");

endmodule

// ===== hdl/dqpb_ram.sv =====
module dqpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dqpb_cfg.sv =====
module dqpb_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [dqpb_pkg::CFG_IDX_W-1:0] index,
  input  logic [dqpb_pkg::CFG_W-1:0]     wdata,
  output dqpb_pkg::cfg_t                 cfg
);

  dqpb_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        dqpb_pkg::CFG_IDX_QUERY_ID:  cfg_nxt.id_word = wdata;
        dqpb_pkg::CFG_IDX_OPCODE:    cfg_nxt.opcode  = wdata[3:0];
        dqpb_pkg::CFG_IDX_RECURSION: cfg_nxt.rd_flag = wdata[0];
        dqpb_pkg::CFG_IDX_QTYPE:     cfg_nxt.qtype   = wdata;
        dqpb_pkg::CFG_IDX_QCLASS:    cfg_nxt.qclass  = wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.id_word <= 16'd0;
      cfg_r.opcode  <= 4'd0;
      cfg_r.rd_flag <= 1'b1;
      cfg_r.qtype   <= 16'd1;
      cfg_r.qclass  <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sim/tb_dns_query_packet_builder_core.sv =====
`timescale 1ns / 1ps

module tb_dns_query_packet_builder_core;

  localparam int LABEL_MAX    = 32;
  localparam int RANDOM_CHARS = 350;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 12;

  // indexes past the last register are accepted by the port and ignored
  localparam logic [dqpb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO =
    dqpb_pkg::CFG_IDX_QCLASS + 1'b1;
  localparam logic [dqpb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } wire_byte_t;

  class query_scoreboard;
    logic [15:0] qid;
    logic [3:0]  opcode;
    logic        recursion;
    logic [15:0] qtype;
    logic [15:0] qclass;
    logic [7:0]  label_buf [LABEL_MAX];
    int unsigned fill;
    bit          open;
    bit          truncated;
    wire_byte_t  packet_bytes [$];
    int          errors;

    function new();
      qid       = '0;
      opcode    = '0;
      recursion = 1'b1;
      qtype     = 16'd1;
      qclass    = 16'd1;
      fill      = 0;
      open      = 1'b0;
      truncated = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(logic [dqpb_pkg::CFG_IDX_W-1:0] idx,
                          logic [dqpb_pkg::CFG_W-1:0] val);
      case (idx)
        dqpb_pkg::CFG_IDX_QUERY_ID:  qid       = val;
        dqpb_pkg::CFG_IDX_OPCODE:    opcode    = val[3:0];
        dqpb_pkg::CFG_IDX_RECURSION: recursion = val[0];
        dqpb_pkg::CFG_IDX_QTYPE:     qtype     = val;
        dqpb_pkg::CFG_IDX_QCLASS:    qclass    = val;
        default: ;
      endcase
    endfunction

    function void push(logic [7:0] data, logic last, logic ovf);
      wire_byte_t b;
      b.data = data;
      b.last = last;
      b.ovf  = ovf;
      packet_bytes.push_back(b);
    endfunction

    function void flush_label();
      if (fill == 0) return;
      push(8'(fill), 1'b0, 1'b0);
      for (int k = 0; k < fill; k++) push(label_buf[k], 1'b0, 1'b0);
      fill = 0;
    endfunction

    function void note_char(logic [7:0] c, logic fin);
      logic [15:0] flags;
      if (!open) begin
        flags = {1'b0, opcode, 2'b00, recursion, 8'h00};
        push(qid[15:8], 1'b0, 1'b0);
        push(qid[7:0], 1'b0, 1'b0);
        push(flags[15:8], 1'b0, 1'b0);
        push(flags[7:0], 1'b0, 1'b0);
        push(8'h00, 1'b0, 1'b0);
        push(8'h01, 1'b0, 1'b0);
        repeat (dqpb_pkg::HDR_BYTES - 6) push(8'h00, 1'b0, 1'b0);
        open      = 1'b1;
        fill      = 0;
        truncated = 1'b0;
      end
      if (c == dqpb_pkg::SEPARATOR) begin
        flush_label();
      end else if (fill < LABEL_MAX) begin
        label_buf[fill] = c;
        fill++;
      end else begin
        truncated = 1'b1;
      end
      if (fin) begin
        flush_label();
        push(8'h00, 1'b0, 1'b0);
        push(qtype[15:8], 1'b0, 1'b0);
        push(qtype[7:0], 1'b0, 1'b0);
        push(qclass[15:8], 1'b0, 1'b0);
        push(qclass[7:0], 1'b1, truncated);
        open      = 1'b0;
        truncated = 1'b0;
        fill      = 0;
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic ovf);
      wire_byte_t exp_b;
      if (packet_bytes.size() == 0) begin
        $error("packet byte %h with nothing outstanding", data);
        errors++;
        return;
      end
      exp_b = packet_bytes.pop_front();
      if (data !== exp_b.data) begin
        $error("packet_byte: expected %h, got %h", exp_b.data, data);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("packet_last: expected %b, got %b", exp_b.last, last);
        errors++;
      end
      if (ovf !== exp_b.ovf) begin
        $error("label_overflow: expected %b, got %b", exp_b.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return packet_bytes.size();
    endfunction
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;  // name_char
  logic                           in_tlast   = 1'b0;  // name_end
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;  // packet_byte
  logic                           out_tlast;  // packet_last
  logic                           out_tuser;  // label_overflow
  logic                           cfg_we     = 1'b0;
  logic [dqpb_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [dqpb_pkg::CFG_W-1:0]     cfg_wdata  = '0;

  query_scoreboard sb;
  logic [7:0]      name_q [$];
  int              chars_sent = 0;
  int              cycles = 0;
  bit              quiet = 1'b0;

  dns_query_packet_builder_core #(
    .LABEL_MAX(LABEL_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check each transaction, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
      out_tready <= quiet || ($urandom_range(0, 99) >= 13);
    end
  end

  task automatic put_reg(logic [dqpb_pkg::CFG_IDX_W-1:0] idx,
                         logic [dqpb_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [dqpb_pkg::CFG_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return dqpb_pkg::CFG_W'($urandom);
    endcase
  endfunction

  task automatic retune();
    if ($urandom_range(0, 1)) put_reg(dqpb_pkg::CFG_IDX_QUERY_ID, pick_value());
    if ($urandom_range(0, 1)) put_reg(dqpb_pkg::CFG_IDX_OPCODE, pick_value());
    if ($urandom_range(0, 1)) put_reg(dqpb_pkg::CFG_IDX_RECURSION, pick_value());
    if ($urandom_range(0, 1)) put_reg(dqpb_pkg::CFG_IDX_QTYPE, pick_value());
    if ($urandom_range(0, 1)) put_reg(dqpb_pkg::CFG_IDX_QCLASS, pick_value());
    if ($urandom_range(0, 7) == 0)
      put_reg(dqpb_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
              pick_value());
    cfg_we <= 1'b0;
  endtask

  task automatic send_char(logic [7:0] c, logic fin);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(c, fin);
    chars_sent++;
  endtask

  task automatic send_name();
    foreach (name_q[i]) send_char(name_q[i], i == name_q.size() - 1);
    in_tvalid <= 1'b0;
  endtask

  // wait for the packet to drain, plus the pipeline tail, before touching registers
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_name();
    int nlab;
    int len;
    int kind;
    nlab = $urandom_range(1, 4);
    name_q.delete();
    for (int l = 0; l < nlab; l++) begin
      if (l > 0) name_q.push_back(dqpb_pkg::SEPARATOR);
      kind = $urandom_range(0, 99);
      if (kind < 8)       len = 0;
      else if (kind < 18) len = $urandom_range(LABEL_MAX - 1, LABEL_MAX + 6);
      else                len = $urandom_range(1, 10);
      repeat (len) name_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) name_q.push_back(dqpb_pkg::SEPARATOR);
    if (name_q.size() == 0) name_q.push_back(dqpb_pkg::SEPARATOR);
    send_name();
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_reg(dqpb_pkg::CFG_IDX_QUERY_ID, 16'hFFFF);
    put_reg(dqpb_pkg::CFG_IDX_OPCODE, 16'h000F);
    put_reg(dqpb_pkg::CFG_IDX_RECURSION, 16'h0000);
    put_reg(dqpb_pkg::CFG_IDX_QTYPE, 16'hFFFF);
    put_reg(dqpb_pkg::CFG_IDX_QCLASS, 16'h0000);
    cfg_we <= 1'b0;
    @(posedge clk);

    // lone dot gives the root name
    name_q = '{dqpb_pkg::SEPARATOR};
    send_name();
    settle();
    name_q = '{8'h00};
    send_name();
    settle();
    // double dot and trailing dot
    name_q = '{8'hFF, dqpb_pkg::SEPARATOR, dqpb_pkg::SEPARATOR, 8'h41,
               dqpb_pkg::SEPARATOR};
    send_name();
    settle();

    put_reg(dqpb_pkg::CFG_IDX_QUERY_ID, 16'h0000);
    put_reg(dqpb_pkg::CFG_IDX_OPCODE, 16'h0000);
    put_reg(dqpb_pkg::CFG_IDX_RECURSION, 16'hFFFF);
    put_reg(dqpb_pkg::CFG_IDX_QTYPE, 16'h0001);
    put_reg(dqpb_pkg::CFG_IDX_QCLASS, 16'hFFFF);
    put_reg(CFG_IDX_SPARE_LO, 16'hA5A5);
    put_reg(CFG_IDX_SPARE_HI, 16'h5A5A);
    cfg_we <= 1'b0;
    @(posedge clk);

    // leading dot
    name_q = '{dqpb_pkg::SEPARATOR, 8'h7A};
    send_name();
    settle();
    name_q = '{8'h61, 8'h62, dqpb_pkg::SEPARATOR, 8'h63, 8'h80, 8'h7F};
    send_name();
    settle();

    while (chars_sent < RANDOM_CHARS) begin
      quiet = (chars_sent > 130 && chars_sent < 230);
      send_random_name();
      settle();
      if ($urandom_range(0, 2) == 0) begin
        retune();
        @(posedge clk);
      end
    end
    quiet = 1'b0;

    settle();
    if (sb.pending() != 0) begin
      $error("%0d packet bytes never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dqpb_pkg.sv
hdl/dqpb_ram.sv
hdl/dqpb_cfg.sv
hdl/dns_query_packet_builder_core.sv
sim/tb_dns_query_packet_builder_core.sv
